FILE: src/aidr_pkg.sv
// aidr_pkg: shared constants, command and status codes for the array editor
// depends on nothing; used by array_insert_delete_rotate_top
package aidr_pkg;

  // store geometry
  localparam int CAPACITY = 8;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int LEN_W    = ADDR_W + 1;
  localparam int DATA_W   = 32;
  localparam int AMT_W    = 16;
  localparam int BIT_W    = $clog2(AMT_W);

  // command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_ROTATE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  // pending memory write, issued in the cycle after its read
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic              from_scr;
  } wr_pend_t;

endpackage

FILE: src/array_insert_delete_rotate_top.sv
// array_insert_delete_rotate_top: ordered array editor built around a registered-read element ram
// depends on aidr_pkg for constants, codes and the pending-write struct
//
// sequence: read, refused command or empty segment go via fetch to the result register;
//   append writes the value directly, other insert shifts elements up first, delete shifts
//   elements down (none for the last entry); rotate runs a bit-serial modulo of the amount,
//   then copies through a scratch ram and back, skipped when the amount reduces to zero
// handshake: one command at a time; the next transfer is taken
//   the cycle after the result register loads
// reset: count cleared, stored elements read as zero; no clearing pass needed
module array_insert_delete_rotate_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_cmd,
  input  logic [aidr_pkg::ADDR_W-1:0]          in_position,
  input  logic signed [aidr_pkg::DATA_W-1:0]   in_item_value,
  input  logic [aidr_pkg::ADDR_W-1:0]          in_segment_end,
  input  logic signed [aidr_pkg::AMT_W-1:0]    in_rotate_amount,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic [aidr_pkg::CNT_W-1:0]           out_element_count,
  output logic signed [aidr_pkg::DATA_W-1:0]   out_read_value
);

  localparam int ADDR_W = aidr_pkg::ADDR_W;
  localparam int CNT_W  = aidr_pkg::CNT_W;
  localparam int LEN_W  = aidr_pkg::LEN_W;
  localparam int DATA_W = aidr_pkg::DATA_W;
  localparam int AMT_W  = aidr_pkg::AMT_W;
  localparam int BIT_W  = aidr_pkg::BIT_W;
  localparam int CAP    = aidr_pkg::CAPACITY;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_MOD    = 10'b00_0000_0010,
    S_FIX    = 10'b00_0000_0100,
    S_MOVE   = 10'b00_0000_1000,
    S_DRAIN  = 10'b00_0001_0000,
    S_PUT    = 10'b00_0010_0000,
    S_ROT_LD = 10'b00_0100_0000,
    S_ROT_ST = 10'b00_1000_0000,
    S_FETCH  = 10'b01_0000_0000,
    S_RESP   = 10'b10_0000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  aidr_pkg::cmd_t           cmd_r, cmd_nxt;
  aidr_pkg::status_t        res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]        pos_r, pos_nxt;
  logic [DATA_W-1:0]        val_r, val_nxt;
  logic                     neg_r, neg_nxt;
  logic [AMT_W-1:0]         mag_r, mag_nxt;
  logic [BIT_W-1:0]         bit_r, bit_nxt;
  logic [ADDR_W-1:0]        rem_r, rem_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [ADDR_W-1:0]        off_r, off_nxt;
  logic [ADDR_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  aidr_pkg::wr_pend_t       wp_r, wp_nxt;
  logic                     scr_wen_r, scr_wen_nxt;
  logic [ADDR_W-1:0]        scr_waddr_r, scr_waddr_nxt;
  logic                     out_valid_r, out_valid_nxt;
  aidr_pkg::status_t        out_status_r;
  logic [CNT_W-1:0]         out_count_r;
  logic [DATA_W-1:0]        out_value_r;

  // element ram and scratch ram for rotation
  logic [DATA_W-1:0]        elem_mem_r [CAP];
  logic [DATA_W-1:0]        scr_mem_r  [CAP];
  logic [DATA_W-1:0]        mem_rdata_r;
  logic [DATA_W-1:0]        scr_rdata_r;

  logic                     mem_we, mem_re, scr_re;
  logic [ADDR_W-1:0]        mem_waddr, mem_raddr, scr_raddr;
  logic [DATA_W-1:0]        mem_wdata;

  logic                     accept;
  logic                     out_load;
  aidr_pkg::cmd_t           in_cmd_c;
  logic [ADDR_W:0]          trial;
  logic [ADDR_W-1:0]        rem_step;
  logic [ADDR_W-1:0]        rot_amt;
  logic [LEN_W-1:0]         last_off;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign in_cmd_c  = aidr_pkg::cmd_t'(in_cmd);
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || out_ready);
  assign last_off  = len_r - LEN_W'(1);

  // one restoring step of the amount modulo segment length
  assign trial    = {rem_r, mag_r[AMT_W-1]};
  assign rem_step = (LEN_W'(trial) >= len_r) ? ADDR_W'(LEN_W'(trial) - len_r)
                                             : trial[ADDR_W-1:0];

  // negative amounts wrap to the equivalent left rotation
  assign rot_amt = !neg_r        ? rem_r :
                   (rem_r == '0) ? '0    : ADDR_W'(len_r - LEN_W'(rem_r));

  // next-state and control
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    res_status_nxt = res_status_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    bit_nxt        = bit_r;
    rem_nxt        = rem_r;
    len_nxt        = len_r;
    off_nxt        = off_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    wp_nxt         = '0;
    scr_wen_nxt    = 1'b0;
    scr_waddr_nxt  = scr_waddr_r;
    mem_re         = 1'b0;
    mem_raddr      = pos_r;
    scr_re         = 1'b0;
    scr_raddr      = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt        = in_cmd_c;
          pos_nxt        = in_position;
          val_nxt        = in_item_value;
          neg_nxt        = in_rotate_amount[AMT_W-1];
          mag_nxt        = in_rotate_amount[AMT_W-1] ? AMT_W'(-in_rotate_amount)
                                                     : in_rotate_amount;
          len_nxt        = LEN_W'(in_segment_end) - LEN_W'(in_position) + LEN_W'(1);
          bit_nxt        = '0;
          rem_nxt        = '0;
          res_status_nxt = aidr_pkg::ST_OK;
          state_nxt      = S_FETCH;
          unique case (in_cmd_c)
            aidr_pkg::CMD_INSERT: begin
              if (count_r >= CNT_W'(CAP)) begin
                res_status_nxt = aidr_pkg::ST_FULL;
              end else if (CNT_W'(in_position) > count_r) begin
                res_status_nxt = aidr_pkg::ST_BADIDX;
              end else begin
                count_nxt = count_r + CNT_W'(1);
                idx_nxt   = ADDR_W'(count_r - CNT_W'(1));
                state_nxt = (CNT_W'(in_position) == count_r) ? S_PUT : S_MOVE;
              end
            end
            aidr_pkg::CMD_DELETE: begin
              if (count_r == '0) begin
                res_status_nxt = aidr_pkg::ST_EMPTY;
              end else if (CNT_W'(in_position) >= count_r) begin
                res_status_nxt = aidr_pkg::ST_BADIDX;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                idx_nxt   = in_position + ADDR_W'(1);
                state_nxt = (CNT_W'(in_position) == count_r - CNT_W'(1)) ? S_FETCH
                                                                         : S_MOVE;
              end
            end
            aidr_pkg::CMD_ROTATE: begin
              if (in_segment_end >= in_position) begin
                if (CNT_W'(in_segment_end) >= count_r) begin
                  res_status_nxt = aidr_pkg::ST_BADIDX;
                end else begin
                  state_nxt = S_MOD;
                end
              end
            end
            aidr_pkg::CMD_READ: begin
              if (CNT_W'(in_position) >= count_r) begin
                res_status_nxt = aidr_pkg::ST_BADIDX;
              end
            end
            default: state_nxt = S_FETCH;
          endcase
        end
      end

      // bit-serial remainder, msb first
      S_MOD: begin
        rem_nxt = rem_step;
        mag_nxt = mag_r << 1;
        bit_nxt = bit_r + BIT_W'(1);
        if (bit_r == BIT_W'(AMT_W - 1)) begin
          state_nxt = S_FIX;
        end
      end

      S_FIX: begin
        off_nxt   = rot_amt;
        idx_nxt   = '0;
        state_nxt = (rot_amt == '0) ? S_FETCH : S_ROT_LD;
      end

      // shift elements up (insert) or down (delete), one read per cycle
      S_MOVE: begin
        mem_re    = 1'b1;
        mem_raddr = idx_r;
        wp_nxt.en = 1'b1;
        if (cmd_r == aidr_pkg::CMD_INSERT) begin
          wp_nxt.addr = idx_r + ADDR_W'(1);
          idx_nxt     = idx_r - ADDR_W'(1);
          if (idx_r == pos_r) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          wp_nxt.addr = idx_r - ADDR_W'(1);
          idx_nxt     = idx_r + ADDR_W'(1);
          if (CNT_W'(idx_r) == count_r) begin
            state_nxt = S_DRAIN;
          end
        end
      end

      // last pending write lands here
      S_DRAIN: begin
        state_nxt = (cmd_r == aidr_pkg::CMD_INSERT) ? S_PUT : S_FETCH;
      end

      S_PUT: begin
        state_nxt = S_FETCH;
      end

      // copy segment in rotated order into scratch
      S_ROT_LD: begin
        mem_re        = 1'b1;
        mem_raddr     = pos_r + off_r;
        scr_wen_nxt   = 1'b1;
        scr_waddr_nxt = idx_r;
        off_nxt       = (LEN_W'(off_r) == last_off) ? '0 : off_r + ADDR_W'(1);
        idx_nxt       = idx_r + ADDR_W'(1);
        if (LEN_W'(idx_r) == last_off) begin
          idx_nxt   = '0;
          state_nxt = S_ROT_ST;
        end
      end

      // copy scratch back into the segment in order
      S_ROT_ST: begin
        scr_re          = 1'b1;
        scr_raddr       = idx_r;
        wp_nxt.en       = 1'b1;
        wp_nxt.addr     = pos_r + idx_r;
        wp_nxt.from_scr = 1'b1;
        idx_nxt         = idx_r + ADDR_W'(1);
        if (LEN_W'(idx_r) == last_off) begin
          state_nxt = S_DRAIN;
        end
      end

      S_FETCH: begin
        mem_re    = 1'b1;
        mem_raddr = pos_r;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // element ram write port: pending copy or the inserted value
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wp_r.addr;
    mem_wdata = wp_r.from_scr ? scr_rdata_r : mem_rdata_r;
    if (wp_r.en) begin
      mem_we = 1'b1;
    end else if (state_r == S_PUT) begin
      mem_we    = 1'b1;
      mem_waddr = pos_r;
      mem_wdata = val_r;
    end
  end

  // element ram
  always_ff @(posedge clk) begin
    if (mem_we) begin
      elem_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= elem_mem_r[mem_raddr];
    end
  end

  // scratch ram
  always_ff @(posedge clk) begin
    if (scr_wen_r) begin
      scr_mem_r[scr_waddr_r] <= mem_rdata_r;
    end
    if (scr_re) begin
      scr_rdata_r <= scr_mem_r[scr_raddr];
    end
  end

  // output register handshake
  assign out_valid_nxt = out_load | (out_valid_r & ~out_ready);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wp_r        <= '0;
      scr_wen_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wp_r        <= wp_nxt;
      scr_wen_r   <= scr_wen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    res_status_r <= res_status_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    neg_r        <= neg_nxt;
    mag_r        <= mag_nxt;
    bit_r        <= bit_nxt;
    rem_r        <= rem_nxt;
    len_r        <= len_nxt;
    off_r        <= off_nxt;
    idx_r        <= idx_nxt;
    scr_waddr_r  <= scr_waddr_nxt;
  end

  // result payload; slots at or above the count read as zero
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_count_r  <= count_r;
      out_value_r  <= (CNT_W'(pos_r) < count_r) ? mem_rdata_r : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element_count = out_count_r;
  assign out_read_value    = $signed(out_value_r);

endmodule
